>>> src/cds_pkg.sv
// Package for the Smith complex divider: widths, item types and helpers.
// Depends on nothing; every other file imports it.
package cds_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int RQ_BITS  = FRAC_BITS + 1;
  localparam int R_BITS   = FRAC_BITS + 2;
  localparam int RN_BITS  = WORD_BITS + FRAC_BITS;
  localparam int EXT_BITS = WORD_BITS + 2;
  localparam int DM_BITS  = WORD_BITS + 1;
  localparam int QQ_BITS  = WORD_BITS + 1;
  localparam int QN_BITS  = WORD_BITS + 1 + FRAC_BITS;
  localparam int CMP_BITS = 2 * WORD_BITS + 2;
  localparam int P_BITS   = R_BITS + WORD_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        umag_t;
  typedef logic signed [EXT_BITS-1:0]  ext_t;
  typedef logic signed [R_BITS-1:0]    ratio_val_t;

  typedef struct packed {
    word_t num_real;
    word_t num_imag;
    word_t div_real;
    word_t div_imag;
  } in_word_t;

  typedef struct packed {
    word_t quot_real;
    word_t quot_imag;
    logic  zero_divisor;
    logic  clipped;
  } out_word_t;

  typedef struct packed {
    word_t cr;
    word_t ci;
    word_t l;
    word_t s;
    logic  imag_branch;
    logic  zero;
  } sel_t;

  typedef struct packed {
    sel_t       sel;
    ratio_val_t r;
  } ratio_t;

  typedef struct packed {
    logic [QN_BITS-1:0] nr_mag;
    logic [QN_BITS-1:0] ni_mag;
    logic               nr_neg;
    logic               ni_neg;
    logic [DM_BITS-1:0] den_mag;
    logic               den_neg;
    logic               zero;
  } quot_in_t;

  function automatic umag_t mag_of(word_t v);
    return v[WORD_BITS-1] ? umag_t'(-v) : umag_t'(v);
  endfunction

endpackage

>>> src/cds_if.sv
// Valid/ready channel interfaces for the divider's input and result words.
// Depends on cds_pkg.
interface cds_in_if import cds_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t num_real;
  word_t num_imag;
  word_t div_real;
  word_t div_imag;
  modport source(output valid, num_real, num_imag, div_real, div_imag, input ready);
  modport sink(input valid, num_real, num_imag, div_real, div_imag, output ready);
endinterface

interface cds_out_if import cds_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t quot_real;
  word_t quot_imag;
  logic  zero_divisor;
  logic  clipped;
  modport source(output valid, quot_real, quot_imag, zero_divisor, clipped, input ready);
  modport sink(input valid, quot_real, quot_imag, zero_divisor, clipped, output ready);
endinterface

>>> src/cds_ratio_div.sv
// Divisor part selection and pipelined ratio divider, one quotient bit a stage.
// Depends on cds_pkg.
module cds_ratio_div import cds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  in_word_t item_i,
  output logic     valid_o,
  output ratio_t   ratio_o
);

  localparam int Steps = RQ_BITS;

  typedef struct packed {
    sel_t               sel;
    umag_t              lmag;
    logic [RN_BITS-1:0] rem;
    logic [RQ_BITS-1:0] q;
    logic               neg;
  } rstage_t;

  rstage_t          st_q [Steps+1];
  logic [Steps:0]   vld_q;
  rstage_t          sel_d;
  umag_t            mr, mi, smag;
  logic             real_big;
  ratio_val_t       rv;

  always_comb begin
    mr       = mag_of(item_i.div_real);
    mi       = mag_of(item_i.div_imag);
    real_big = mr >= mi;
    smag     = real_big ? mi : mr;
    sel_d.sel.cr          = item_i.num_real;
    sel_d.sel.ci          = item_i.num_imag;
    sel_d.sel.l           = real_big ? item_i.div_real : item_i.div_imag;
    sel_d.sel.s           = real_big ? item_i.div_imag : item_i.div_real;
    sel_d.sel.imag_branch = !real_big;
    sel_d.sel.zero        = (item_i.div_real == '0) && (item_i.div_imag == '0);
    sel_d.lmag            = real_big ? mr : mi;
    sel_d.rem             = {smag, {FRAC_BITS{1'b0}}};
    sel_d.q               = '0;
    sel_d.neg             = item_i.div_real[WORD_BITS-1] ^ item_i.div_imag[WORD_BITS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= sel_d;
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int Sh = Steps - 1 - j;
    logic [RN_BITS-1:0] sd;
    logic               ge;
    rstage_t            nx;

    always_comb begin
      nx   = st_q[j];
      sd   = RN_BITS'(st_q[j].lmag) << Sh;
      ge   = st_q[j].rem >= sd;
      if (ge) begin
        nx.rem = st_q[j].rem - sd;
      end
      nx.q = {st_q[j].q[RQ_BITS-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j+1] <= nx;
      end
    end
  end

  assign rv        = $signed({1'b0, st_q[Steps].q});
  assign valid_o   = vld_q[Steps];
  assign ratio_o.sel = st_q[Steps].sel;
  assign ratio_o.r = st_q[Steps].neg ? -rv : rv;

endmodule

>>> src/cds_combine.sv
// Scaled products, denominator and numerator sums, then magnitudes and signs.
// Depends on cds_pkg.
module cds_combine import cds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  ratio_t   ratio_i,
  output logic     valid_o,
  output quot_in_t quot_o
);

  typedef struct packed {
    sel_t sel;
    ext_t pcr;
    ext_t pci;
    ext_t ps;
  } prod_t;

  typedef struct packed {
    ext_t den;
    ext_t nr;
    ext_t ni;
    logic zero;
  } sum_t;

  function automatic logic [DM_BITS-1:0] ext_mag(ext_t v);
    ext_t m;
    m = v[EXT_BITS-1] ? -v : v;
    return m[DM_BITS-1:0];
  endfunction

  logic signed [P_BITS-1:0] mcr, mci, ms;
  prod_t    prod_d, prod_q;
  sum_t     sum_d, sum_q;
  quot_in_t quot_d, quot_q;
  logic [2:0] vld_q;

  always_comb begin
    mcr = ratio_i.r * ratio_i.sel.cr;
    mci = ratio_i.r * ratio_i.sel.ci;
    ms  = ratio_i.r * ratio_i.sel.s;
    prod_d.sel = ratio_i.sel;
    prod_d.pcr = ext_t'(mcr >>> FRAC_BITS);
    prod_d.pci = ext_t'(mci >>> FRAC_BITS);
    prod_d.ps  = ext_t'(ms >>> FRAC_BITS);
  end

  always_comb begin
    sum_d.den  = ext_t'(prod_q.sel.l) + prod_q.ps;
    sum_d.zero = prod_q.sel.zero;
    if (prod_q.sel.imag_branch) begin
      sum_d.nr = prod_q.pcr + ext_t'(prod_q.sel.ci);
      sum_d.ni = prod_q.pci - ext_t'(prod_q.sel.cr);
    end else begin
      sum_d.nr = ext_t'(prod_q.sel.cr) + prod_q.pci;
      sum_d.ni = ext_t'(prod_q.sel.ci) - prod_q.pcr;
    end
  end

  always_comb begin
    quot_d.nr_mag  = {ext_mag(sum_q.nr), {FRAC_BITS{1'b0}}};
    quot_d.ni_mag  = {ext_mag(sum_q.ni), {FRAC_BITS{1'b0}}};
    quot_d.nr_neg  = sum_q.nr[EXT_BITS-1];
    quot_d.ni_neg  = sum_q.ni[EXT_BITS-1];
    quot_d.den_mag = ext_mag(sum_q.den);
    quot_d.den_neg = sum_q.den[EXT_BITS-1];
    quot_d.zero    = sum_q.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
      quot_q <= quot_d;
    end
  end

  assign valid_o = vld_q[2];
  assign quot_o  = quot_q;

endmodule

>>> src/cds_quot_div.sv
// Pipelined quotient dividers for both parts, overflow check and saturation.
// Depends on cds_pkg.
module cds_quot_div import cds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  quot_in_t  quot_i,
  output logic      valid_o,
  output out_word_t word_o
);

  localparam int Steps = QQ_BITS;

  typedef struct packed {
    logic [QN_BITS-1:0] rem;
    logic [QQ_BITS-1:0] q;
    logic               ovf;
    logic               neg;
  } lane_t;

  typedef struct packed {
    lane_t              re;
    lane_t              im;
    logic [DM_BITS-1:0] den_mag;
    logic               zero;
  } qstage_t;

  typedef struct packed {
    word_t v;
    logic  clip;
  } sat_t;

  function automatic lane_t lane_init(logic [QN_BITS-1:0] num, logic neg,
                                      logic [DM_BITS-1:0] den);
    lane_t l;
    l.rem = num;
    l.q   = '0;
    l.ovf = CMP_BITS'(num) >= (CMP_BITS'(den) << QQ_BITS);
    l.neg = neg;
    return l;
  endfunction

  function automatic lane_t lane_step(lane_t l, logic [DM_BITS-1:0] den, int sh);
    lane_t              n;
    logic [CMP_BITS-1:0] sd;
    logic               ge;
    n  = l;
    sd = CMP_BITS'(den) << sh;
    ge = CMP_BITS'(l.rem) >= sd;
    if (ge) begin
      n.rem = l.rem - sd[QN_BITS-1:0];
    end
    n.q = {l.q[QQ_BITS-2:0], ge};
    return n;
  endfunction

  function automatic sat_t lane_sat(lane_t l);
    sat_t               s;
    logic [QQ_BITS-1:0] lim, mv, sv;
    lim    = l.neg ? (QQ_BITS'(1) << (WORD_BITS-1))
                   : (QQ_BITS'(1) << (WORD_BITS-1)) - QQ_BITS'(1);
    s.clip = l.ovf || (l.q > lim);
    mv     = s.clip ? lim : l.q;
    sv     = l.neg ? -mv : mv;
    s.v    = sv[WORD_BITS-1:0];
    return s;
  endfunction

  qstage_t        st_q [Steps+1];
  logic [Steps:0] vld_q;
  qstage_t        init_d;
  sat_t           sr, si;
  out_word_t      word_d, word_q;
  logic           out_vld_q;

  always_comb begin
    init_d.re      = lane_init(quot_i.nr_mag, quot_i.nr_neg ^ quot_i.den_neg, quot_i.den_mag);
    init_d.im      = lane_init(quot_i.ni_mag, quot_i.ni_neg ^ quot_i.den_neg, quot_i.den_mag);
    init_d.den_mag = quot_i.den_mag;
    init_d.zero    = quot_i.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= init_d;
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int Sh = Steps - 1 - j;
    qstage_t nx;

    always_comb begin
      nx    = st_q[j];
      nx.re = lane_step(st_q[j].re, st_q[j].den_mag, Sh);
      nx.im = lane_step(st_q[j].im, st_q[j].den_mag, Sh);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j+1] <= nx;
      end
    end
  end

  always_comb begin
    sr = lane_sat(st_q[Steps].re);
    si = lane_sat(st_q[Steps].im);
    if (st_q[Steps].zero) begin
      word_d = '{quot_real: '0, quot_imag: '0, zero_divisor: 1'b1, clipped: 1'b0};
    end else begin
      word_d = '{quot_real: sr.v, quot_imag: si.v, zero_divisor: 1'b0,
                 clipped: sr.clip | si.clip};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = out_vld_q;
  assign word_o  = word_q;

endmodule

>>> src/complex_divide_smith_top.sv
// Smith complex divider, signed Q16.16: top level tying the pipeline together.
// Depends on cds_pkg, cds_if, cds_ratio_div, cds_combine and cds_quot_div.
//
// Takes one word (numerator and divisor, each complex) per cycle while the output
// is not stalled and returns one quotient word per input, in order, through 56
// register stages: two bit-per-stage restoring dividers, 17 stages for the ratio
// of the divisor parts and 33 for the quotient parts, plus selection, three
// multiply/sum stages, the overflow check and the output register. The whole
// pipeline holds when the output word is not taken; ready is low only then.
module complex_divide_smith_top import cds_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  cds_in_if.sink   in_i,
  cds_out_if.source out_o
);

  logic      en;
  in_word_t  item;
  logic      ratio_vld, quot_vld;
  ratio_t    ratio;
  quot_in_t  quot_in;
  out_word_t res;

  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign item     = '{num_real: in_i.num_real, num_imag: in_i.num_imag,
                      div_real: in_i.div_real, div_imag: in_i.div_imag};

  cds_ratio_div u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .item_i  (item),
    .valid_o (ratio_vld),
    .ratio_o (ratio)
  );

  cds_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ratio_vld),
    .ratio_i (ratio),
    .valid_o (quot_vld),
    .quot_o  (quot_in)
  );

  cds_quot_div u_quot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (quot_vld),
    .quot_i  (quot_in),
    .valid_o (out_o.valid),
    .word_o  (res)
  );

  assign out_o.quot_real    = res.quot_real;
  assign out_o.quot_imag    = res.quot_imag;
  assign out_o.zero_divisor = res.zero_divisor;
  assign out_o.clipped      = res.clipped;

  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_divisor |->
      out_o.quot_real == '0 && out_o.quot_imag == '0 && !out_o.clipped)
    else $error("zero divisor word not cleared");

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.clipped |->
      out_o.quot_real == {1'b0, {(WORD_BITS-1){1'b1}}} ||
      out_o.quot_real == {1'b1, {(WORD_BITS-1){1'b0}}} ||
      out_o.quot_imag == {1'b0, {(WORD_BITS-1){1'b1}}} ||
      out_o.quot_imag == {1'b1, {(WORD_BITS-1){1'b0}}})
    else $error("clipped word not at a bound");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input held without back-pressure");

endmodule
